[design/text_sanitize_latin1_utf8_macros.svh]
// ----------------------------------------------------------------------------
// Text sanitizer assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef TEXT_SANITIZE_LATIN1_UTF8_MACROS_SVH
`define TEXT_SANITIZE_LATIN1_UTF8_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define TSL_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define TSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tsl_pkg.sv]
// ----------------------------------------------------------------------------
// Text sanitizer package
// Widths, character codes, run type and hex digit helper.
// ----------------------------------------------------------------------------
package tsl_pkg;

    localparam int CP_W      = 21;
    localparam int MAX_RUN   = 10;
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_LO_U   = 8'h75;
    localparam logic [7:0] CHR_UP_U   = 8'h55;

    typedef logic [CP_W-1:0] code_point_t;

    // Bytes of one run, first byte out at index 0, plus the byte count.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    count;
    } run_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        w = {4'b0000, v};
        if (v < 4'd10)
        begin
            return 8'h30 + w;
        end
        return 8'h57 + w;
    endfunction

endpackage

[design/tsl_encode.sv]
// ----------------------------------------------------------------------------
// Text sanitizer encoder
// Turns one code point into a run of 0 to 10 output bytes.
// ----------------------------------------------------------------------------
module tsl_encode (
    input  tsl_pkg::code_point_t code_point,
    input  logic                 latin1_mode,
    input  logic                 cr_pending,
    output tsl_pkg::run_t        run,
    output logic                 cr_next
);
    import tsl_pkg::*;

    logic        is_cr;
    logic        swallow;
    logic        is_ctrl;
    logic [31:0] cp32;

    assign cp32    = {11'b0, code_point};
    assign is_cr   = (code_point == {13'b0, CHR_CR});
    assign swallow = cr_pending && (code_point == {13'b0, CHR_LF});
    assign is_ctrl = ((code_point < 21'h20) && (code_point != {13'b0, CHR_TAB})
                      && (code_point != {13'b0, CHR_LF}))
                     || ((code_point >= 21'h7F) && (code_point < 21'hA0));
    assign cr_next = is_cr;

    always_comb
    begin
        run = '0;
        priority if (is_cr)
        begin
            run.bytes[0] = CHR_LF;
            run.count    = RUN_CNT_W'(1);
        end
        else if (swallow || is_ctrl)
        begin
            run.count = '0;
        end
        else if (latin1_mode)
        begin
            priority if (code_point <= 21'hFF)
            begin
                run.bytes[0] = code_point[7:0];
                run.count    = RUN_CNT_W'(1);
            end
            else if (code_point < 21'h10000)
            begin
                run.bytes[0] = CHR_BSLASH;
                run.bytes[1] = CHR_LO_U;
                for (int i = 0; i < 4; i++)
                begin
                    run.bytes[2+i] = hex_digit(cp32[4*(3-i) +: 4]);
                end
                run.count = RUN_CNT_W'(6);
            end
            else
            begin
                run.bytes[0] = CHR_BSLASH;
                run.bytes[1] = CHR_UP_U;
                for (int i = 0; i < 8; i++)
                begin
                    run.bytes[2+i] = hex_digit(cp32[4*(7-i) +: 4]);
                end
                run.count = RUN_CNT_W'(10);
            end
        end
        else
        begin
            priority if (code_point < 21'h80)
            begin
                run.bytes[0] = code_point[7:0];
                run.count    = RUN_CNT_W'(1);
            end
            else if (code_point < 21'h800)
            begin
                run.bytes[0] = {3'b110, code_point[10:6]};
                run.bytes[1] = {2'b10, code_point[5:0]};
                run.count    = RUN_CNT_W'(2);
            end
            else if (code_point < 21'h10000)
            begin
                run.bytes[0] = {4'b1110, code_point[15:12]};
                run.bytes[1] = {2'b10, code_point[11:6]};
                run.bytes[2] = {2'b10, code_point[5:0]};
                run.count    = RUN_CNT_W'(3);
            end
            else
            begin
                run.bytes[0] = {5'b11110, code_point[20:18]};
                run.bytes[1] = {2'b10, code_point[17:12]};
                run.bytes[2] = {2'b10, code_point[11:6]};
                run.bytes[3] = {2'b10, code_point[5:0]};
                run.count    = RUN_CNT_W'(4);
            end
        end
    end

endmodule

[design/tsl_serializer.sv]
// ----------------------------------------------------------------------------
// Text sanitizer serializer
// Holds one run and shifts it out one byte per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tsl_serializer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  tsl_pkg::run_t run,
    output logic          can_load,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          run_last
);
    import tsl_pkg::*;

    logic [MAX_RUN-1:0][7:0] bytes_reg;
    logic [MAX_RUN-1:0][7:0] bytes_next;
    logic [RUN_CNT_W-1:0]    count_reg;
    logic [RUN_CNT_W-1:0]    count_next;
    logic                    take;

    assign out_valid = (count_reg != '0);
    assign run_last  = (count_reg == RUN_CNT_W'(1));
    assign out_byte  = bytes_reg[0];
    assign take      = out_valid && out_ready;
    assign can_load  = !out_valid || (run_last && out_ready);

    always_comb
    begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        priority if (load)
        begin
            bytes_next = run.bytes;
            count_next = run.count;
        end
        else if (take)
        begin
            // advance: drop the byte just taken
            bytes_next = {8'h00, bytes_reg[MAX_RUN-1:1]};
            count_next = count_reg - RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

[design/text_sanitize_latin1_utf8.sv]
// ----------------------------------------------------------------------------
// Text sanitizer, Latin-1 or UTF-8 output
// Filters control characters, folds CR/LF and re-encodes code points.
// ----------------------------------------------------------------------------
// Takes one decoded code point per input beat and emits its bytes, one per
// output beat, with run_last high on the final byte of each code point.
// A code point is encoded in the cycle it is accepted and lands in a run
// buffer of up to ten bytes; the buffer shifts out one byte per cycle while
// out_ready is high. A new code point is accepted whenever the buffer is
// empty or its last byte is taken in the same cycle, so an item holds the
// input until its last byte is taken (1 byte for plain text, 2 to 4 for
// UTF-8, 6 or 10 for Latin-1 escapes); a dropped item (control, or LF after
// CR) loads nothing and emits no beat. latin1_mode resets to 1; the user must
// write it via cfg_we/cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module text_sanitize_latin1_utf8 (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tsl_pkg::code_point_t code_point,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 run_last
);
    import tsl_pkg::*;

    logic latin1_mode_reg;
    logic cr_pending_reg;
    logic cr_next;
    logic accept;
    logic load;
    logic can_load;
    run_t run;

    // Configuration register: 1 selects Latin-1 with hex escapes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latin1_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            latin1_mode_reg <= cfg_wdata;
        end
    end

    tsl_encode u_encode (
        .code_point  (code_point),
        .latin1_mode (latin1_mode_reg),
        .cr_pending  (cr_pending_reg),
        .run         (run),
        .cr_next     (cr_next)
    );

    assign in_ready = can_load;
    assign accept   = in_valid && in_ready;
    // Load the run buffer only for items that produce bytes.
    assign load     = accept && (run.count != '0);

    // Track whether the last accepted beat was a carriage return.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            cr_pending_reg <= cr_next;
        end
    end

    tsl_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .run       (run),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

[design/tsl_checker.sv]
// ----------------------------------------------------------------------------
// Text sanitizer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_sanitize_latin1_utf8_macros.svh"

module tsl_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input tsl_pkg::code_point_t code_point,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [7:0]           out_byte,
    input logic                 run_last
);
    import tsl_pkg::*;

    // An empty output side always takes a new beat.
    `TSL_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready, "input stalled while output empty")
    // A run in the middle of its bytes holds the input.
    `TSL_ASSERT_ALWAYS(a_hold_mid_run, (out_valid && !run_last) |-> !in_ready, "input taken mid-run")
    // A carriage return leaves as a single line feed.
    `TSL_ASSERT_NEXT(a_cr_to_lf, in_valid && in_ready && (code_point == {13'b0, CHR_CR}), out_valid && (out_byte == CHR_LF) && run_last, "CR did not emit one LF")
    // A stalled output beat holds its payload.
    `TSL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last), "stalled output beat changed")

endmodule

bind text_sanitize_latin1_utf8 tsl_checker u_tsl_checker (.*);
